FILE: sv/ttbe_pkg.sv
// Shared constants, types and register codes of the tap tempo estimator.
package ttbe_pkg;

  localparam int MAX_WINDOW_DEF = 8;

  localparam int TIME_W = 32;
  localparam int GAP_W  = 16;
  localparam int WIN_W  = 4;
  localparam int BPM_W  = 14;

  localparam int BPM_SCALE = 600000;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [BPM_W-1:0]  bpm_t;
  typedef logic [GAP_W-1:0]  gap_t;
  typedef logic [WIN_W-1:0]  win_t;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_GAP    = 2'd0;
  localparam reg_idx_t REG_WINDOW = 2'd1;
  localparam reg_idx_t REG_MIN    = 2'd2;
  localparam reg_idx_t REG_MAX    = 2'd3;

  localparam gap_t GAP_RST    = 16'd2000;
  localparam win_t WINDOW_RST = 4'd4;
  localparam bpm_t MIN_RST    = 14'd300;
  localparam bpm_t MAX_RST    = 14'd3000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: sv/ttbe_if.sv
// Handshake channels for tap items and tempo items.
interface ttbe_tap_if;
  import ttbe_pkg::*;
  logic  valid;
  logic  ready;
  time_t tap_time_ms;
  modport source (output valid, output tap_time_ms, input ready);
  modport sink (input valid, input tap_time_ms, output ready);
endinterface

interface ttbe_tempo_if;
  import ttbe_pkg::*;
  logic valid;
  logic ready;
  logic tempo_valid;
  bpm_t bpm_tenths;
  modport source (output valid, output tempo_valid, output bpm_tenths, input ready);
  modport sink (input valid, input tempo_valid, input bpm_tenths, output ready);
endinterface

FILE: sv/tap_tempo_bpm_estimator.sv
// Tap tempo estimator: tap history in a ring memory, tempo by serial division.
// Flow: the first tap of a sequence gives a result with no valid tempo, a zero span gives the configured
// maximum tempo, and otherwise the tempo comes from the one-bit-a-cycle serial divider.
// Throughput: one tap at a time; the next tap is taken once the result is queued.
// Reset: synchronous active-low rst_n empties the history and loads register defaults;
// ring contents stay as they are and are read only after being written.
module tap_tempo_bpm_estimator #(
  parameter int MAX_WINDOW = ttbe_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ttbe_tap_if.sink                    in_tap,
  ttbe_tempo_if.source                out_tempo,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttbe_pkg::CFG_AW-1:0] paddr,
  input  logic [ttbe_pkg::CFG_DW-1:0] pwdata,
  output logic [ttbe_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import ttbe_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int PTR_W  = IDX_W + 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int WCMP_W = ((WIN_W > CNT_W) ? WIN_W : CNT_W) + 1;
  localparam int NUM_W  = $clog2(BPM_SCALE * (MAX_WINDOW - 1) + 1);

  typedef enum logic [2:0] {S_IDLE, S_LAST, S_OLD, S_DIV, S_DONE} state_t;

  // configuration registers
  gap_t cfg_gap_r;
  win_t cfg_win_r;
  bpm_t cfg_min_r;
  bpm_t cfg_max_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_gap_r <= GAP_RST;
      cfg_win_r <= WINDOW_RST;
      cfg_min_r <= MIN_RST;
      cfg_max_r <= MAX_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_GAP:    cfg_gap_r <= pwdata[GAP_W-1:0];
        REG_WINDOW: cfg_win_r <= pwdata[WIN_W-1:0];
        REG_MIN:    cfg_min_r <= pwdata[BPM_W-1:0];
        REG_MAX:    cfg_max_r <= pwdata[BPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_GAP:    prdata = CFG_DW'(cfg_gap_r);
      REG_WINDOW: prdata = CFG_DW'(cfg_win_r);
      REG_MIN:    prdata = CFG_DW'(cfg_min_r);
      REG_MAX:    prdata = CFG_DW'(cfg_max_r);
      default:    prdata = '0;
    endcase
  end

  // control and datapath registers
  state_t           state_r;
  logic [IDX_W-1:0] head_r;
  logic [CNT_W-1:0] cnt_r;
  time_t            now_r;
  logic             tv_r;
  bpm_t             bpm_r;
  logic             out_valid_r;
  logic             out_tv_r;
  bpm_t             out_bpm_r;

  // tap ring
  time_t            ring_mem [MAX_WINDOW];
  time_t            rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             ring_we;

  // effective window
  logic [WCMP_W-1:0] win_ext;
  logic [CNT_W-1:0]  win;

  always_comb begin
    win_ext = WCMP_W'(cfg_win_r);
    if (win_ext < WCMP_W'(2)) begin
      win = CNT_W'(2);
    end else if (win_ext > WCMP_W'(MAX_WINDOW)) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = win_ext[CNT_W-1:0];
    end
  end

  // history update
  logic [IDX_W-1:0] head_prev;
  logic [IDX_W-1:0] head_inc;
  time_t            gap_diff;
  logic             gap_hit;
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W-1:0] cnt_new;
  logic [PTR_W-1:0] old_sum;
  logic [IDX_W-1:0] old_idx;

  always_comb begin
    head_prev = (head_r == '0) ? IDX_W'(MAX_WINDOW - 1) : head_r - 1'b1;
    head_inc  = (head_r == IDX_W'(MAX_WINDOW - 1)) ? '0 : head_r + 1'b1;
    gap_diff  = now_r - rd_data_r;
    gap_hit   = (cnt_r != '0) && (gap_diff > TIME_W'(cfg_gap_r));
    cnt_inc   = gap_hit ? (CNT_W + 1)'(1) : ({1'b0, cnt_r} + 1'b1);
    cnt_new   = (cnt_inc > {1'b0, win}) ? win : cnt_inc[CNT_W-1:0];
    old_sum   = {1'b0, head_inc} + PTR_W'(MAX_WINDOW) - PTR_W'(cnt_new);
    if (old_sum >= PTR_W'(MAX_WINDOW)) begin
      old_sum = old_sum - PTR_W'(MAX_WINDOW);
    end
    old_idx = old_sum[IDX_W-1:0];
  end

  assign rd_addr = (state_r == S_IDLE) ? head_prev : old_idx;
  assign ring_we = (state_r == S_LAST);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[head_r] <= now_r;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  // division
  time_t               span;
  logic [NUM_W-1:0]    dividend;
  logic [NUM_W-1:0]    quotient;
  ttbe_pkg::div_stat_t div_stat;
  logic                div_start;
  logic [NUM_W-1:0]    q_lo;
  logic [NUM_W-1:0]    q_cl;

  always_comb begin
    span      = now_r - rd_data_r;
    dividend  = NUM_W'(BPM_SCALE) * NUM_W'(cnt_r - 1'b1);
    div_start = (state_r == S_OLD) && (span != '0) && !div_stat.busy;
    q_lo      = (quotient < NUM_W'(cfg_min_r)) ? NUM_W'(cfg_min_r) : quotient;
    q_cl      = (q_lo > NUM_W'(cfg_max_r)) ? NUM_W'(cfg_max_r) : q_lo;
  end

  ttbe_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tempo.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tap.valid) begin
            now_r   <= in_tap.tap_time_ms;
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          head_r <= head_inc;
          cnt_r  <= cnt_new;
          if (cnt_new < CNT_W'(2)) begin
            tv_r    <= 1'b0;
            bpm_r   <= '0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_OLD;
          end
        end
        S_OLD: begin
          if (span == '0) begin
            tv_r    <= 1'b1;
            bpm_r   <= cfg_max_r;
            state_r <= S_DONE;
          end else if (!div_stat.busy) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            tv_r    <= 1'b1;
            bpm_r   <= q_cl[BPM_W-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tempo.ready) begin
            out_valid_r <= 1'b1;
            out_tv_r    <= tv_r;
            out_bpm_r   <= bpm_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tap.ready          = (state_r == S_IDLE);
  assign out_tempo.valid       = out_valid_r;
  assign out_tempo.tempo_valid = out_tv_r;
  assign out_tempo.bpm_tenths  = out_bpm_r;

endmodule

FILE: sv/ttbe_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module ttbe_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    dividend,
  input  logic [DEN_W-1:0]    divisor,
  output logic [NUM_W-1:0]    quotient,
  output ttbe_pkg::div_stat_t stat
);
  import ttbe_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        cnt_r  <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: sv/ttbe_chk.sv
// Port-level checks of the tap tempo estimator, bound to the top level.
module ttbe_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_tempo_valid,
  input logic [ttbe_pkg::BPM_W-1:0] out_bpm,
  input logic                 pready
);
  import ttbe_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tempo_valid) && $stable(out_bpm))
    else $error("result item dropped or changed while stalled");

  a_first_tap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tempo_valid |-> out_bpm == '0)
    else $error("tempo reported without a valid tempo");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result item present after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port stalled");

endmodule

bind tap_tempo_bpm_estimator ttbe_chk u_ttbe_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_tap.valid),
  .in_ready        (in_tap.ready),
  .out_valid       (out_tempo.valid),
  .out_ready       (out_tempo.ready),
  .out_tempo_valid (out_tempo.tempo_valid),
  .out_bpm         (out_tempo.bpm_tenths),
  .pready          (pready)
);

FILE: tb/testbench.sv
// Self-checking testbench for the tap tempo estimator: directed and random taps, checked in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ttbe_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 110;
  localparam int HOLD_PHASE     = 8;
  localparam int PAUSE_PHASE    = 5;

  typedef struct packed {
    logic tempo_valid;
    bpm_t bpm_tenths;
  } tempo_t;

  class tempo_scoreboard;
    time_t       taps [MAX_WINDOW_DEF];
    int unsigned head;
    int unsigned held;
    gap_t        gap_ms;
    win_t        window;
    bpm_t        min_bpm;
    bpm_t        max_bpm;
    tempo_t      expected_tempos [$];
    int unsigned mismatches;

    function new();
      head       = 0;
      held       = 0;
      gap_ms     = GAP_RST;
      window     = WINDOW_RST;
      min_bpm    = MIN_RST;
      max_bpm    = MAX_RST;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_GAP:    gap_ms  = value[GAP_W-1:0];
        REG_WINDOW: window  = value[WIN_W-1:0];
        REG_MIN:    min_bpm = value[BPM_W-1:0];
        REG_MAX:    max_bpm = value[BPM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tap(time_t now);
      int unsigned       win;
      time_t             last;
      time_t             span;
      longint unsigned   quot;
      tempo_t            tempo;
      win = window;
      if (win < 2) win = 2;
      if (win > MAX_WINDOW_DEF) win = MAX_WINDOW_DEF;
      if (held > 0) begin
        last = taps[(head + MAX_WINDOW_DEF - 1) % MAX_WINDOW_DEF];
        if (time_t'(now - last) > {16'd0, gap_ms}) held = 0;
      end
      taps[head] = now;
      head = (head + 1) % MAX_WINDOW_DEF;
      held++;
      if (held > win) held = win;
      tempo = '0;
      if (held >= 2) begin
        span = now - taps[(head + MAX_WINDOW_DEF - held) % MAX_WINDOW_DEF];
        tempo.tempo_valid = 1'b1;
        if (span == 0) begin
          tempo.bpm_tenths = max_bpm;
        end else begin
          quot = longint'(BPM_SCALE) * longint'(held - 1) / longint'(span);
          if (quot < min_bpm) quot = min_bpm;
          if (quot > max_bpm) quot = max_bpm;
          tempo.bpm_tenths = quot[BPM_W-1:0];
        end
      end
      expected_tempos = {expected_tempos, tempo};
    endfunction

    function void check_tempo(logic tempo_valid, bpm_t bpm_tenths);
      tempo_t want;
      if (expected_tempos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected tempo item: valid=%0b bpm=%0d", tempo_valid, bpm_tenths);
        return;
      end
      want = expected_tempos.pop_front();
      if (want.tempo_valid !== tempo_valid || want.bpm_tenths !== bpm_tenths) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tempo mismatch: expected valid=%0b bpm=%0d, got valid=%0b bpm=%0d",
                   want.tempo_valid, want.bpm_tenths, tempo_valid, bpm_tenths);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  ttbe_tap_if   tap_ch ();
  ttbe_tempo_if tempo_ch ();

  tempo_scoreboard book = new();

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_reqs    = 0;
  int holds_done   = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  tap_tempo_bpm_estimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tap    (tap_ch),
    .out_tempo (tempo_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tempo receiver: random stalls, plus long hold-offs on request
  initial begin
    tempo_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        tempo_ch.ready <= 1'b0;
      end else begin
        tempo_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && tempo_ch.valid && tempo_ch.ready)
      book.check_tempo(tempo_ch.tempo_valid, tempo_ch.bpm_tenths);
  end

  always @(posedge clk) begin
    if ((tap_ch.valid && tap_ch.ready) || (tempo_ch.valid && tempo_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_tap(input time_t stamp);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      tap_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tap_ch.valid       <= 1'b1;
    tap_ch.tap_time_ms <= stamp;
    @(posedge clk);
    while (!tap_ch.ready) @(posedge clk);
    book.note_tap(stamp);
  endtask

  task automatic drain();
    @(negedge clk);
    tap_ch.valid <= 1'b0;
    while (book.expected_tempos.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_directed();
    time_t opening [13] = '{32'd0, 32'd500, 32'd1000, 32'd1000, 32'd3001, 32'd3001,
                            32'd5001, 32'd5002, 32'd5003, 32'd5004, 32'hFFFF_FFF0,
                            32'h0000_0010, 32'hFFFF_FFFF};
    time_t base;
    base = 32'h1000_0000;
    foreach (opening[i]) send_tap(opening[i]);
    drain();
    write_reg(REG_GAP, 32'hFFFF_FFFF);
    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
    write_reg(REG_MIN, 32'd1);
    write_reg(REG_MAX, 32'd9999);
    for (int i = 0; i < 9; i++) send_tap(base + i * 10000);
    drain();
    write_reg(REG_WINDOW, 32'd0);
    send_tap(base + 80500);
    drain();
    write_reg(REG_MIN, 32'd5000);
    write_reg(REG_MAX, 32'd100);
    send_tap(base + 81000);
    drain();
    write_reg(REG_MIN, 32'd300);
    write_reg(REG_MAX, 32'd3000);
    write_reg(REG_WINDOW, 32'd1);
    send_tap(base + 101000);
  endtask

  task automatic run_phase(input int phase);
    logic [CFG_DW-1:0] gap_raw;
    logic [CFG_DW-1:0] win_raw;
    logic [CFG_DW-1:0] min_raw;
    logic [CFG_DW-1:0] max_raw;
    time_t             clock_ms;
    int unsigned       pick;
    int unsigned       gap;
    drain();
    case (phase)
      0: begin
        gap_raw = GAP_RST;
        win_raw = WINDOW_RST;
        min_raw = MIN_RST;
        max_raw = MAX_RST;
      end
      1: begin
        gap_raw = 32'd65535;
        win_raw = 32'd8;
        min_raw = 32'd1;
        max_raw = 32'd9999;
      end
      2: begin
        gap_raw = 32'd1;
        win_raw = 32'd2;
        min_raw = 32'd1;
        max_raw = 32'd1;
      end
      3: begin
        gap_raw = $urandom;
        win_raw = $urandom;
        min_raw = $urandom;
        max_raw = $urandom;
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       gap_raw = $urandom_range(1, 50);
          1:       gap_raw = $urandom_range(200, 3000);
          default: gap_raw = $urandom_range(1, 65535);
        endcase
        win_raw = $urandom_range(0, 15);
        min_raw = $urandom_range(1, 2000);
        max_raw = $urandom_range(1000, 9999);
      end
    endcase
    write_reg(REG_GAP, gap_raw);
    write_reg(REG_WINDOW, win_raw);
    write_reg(REG_MIN, min_raw);
    write_reg(REG_MAX, max_raw);
    clock_ms = $urandom;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (phase == HOLD_PHASE && i == 5) hold_reqs++;
      if (phase == PAUSE_PHASE && i == PHASE_ITEMS / 2) drain();
      gap  = book.gap_ms;
      pick = $urandom_range(0, 99);
      if (pick < 5)
        clock_ms = $urandom;
      else if (pick < 15)
        clock_ms = clock_ms + gap + 1 + $urandom_range(0, 100000);
      else if (pick < 20)
        clock_ms = clock_ms + gap;
      else if (pick >= 24)
        clock_ms = clock_ms + $urandom_range(0, gap);
      send_tap(clock_ms);
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    tap_ch.valid       <= 1'b0;
    tap_ch.tap_time_ms <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    tx_idle_pct = 38;
    rx_idle_pct = 79;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        tx_idle_pct = 79;
        rx_idle_pct = 38;
      end else if (p == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_phase(p);
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.expected_tempos.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
